FILE: src/qdd_pkg.sv
// Shared types, constants and the Gray-code transition table for the detent decoder.
`default_nettype none

package qdd_pkg;

    // Width of the position and event counters
    localparam int COUNT_WIDTH = 16;

    // Item kinds carried on the input channel
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_RESYNC = 2'd2;

    // Configuration register indexes
    localparam logic REG_EDGES   = 1'b0;
    localparam logic REG_REVERSE = 1'b1;

    // Configuration reset values
    localparam logic [2:0] EDGES_RESET   = 3'd2;
    localparam logic       REVERSE_RESET = 1'b0;

    // Bit widths of the packed result fields
    localparam int POS_W   = 16;
    localparam int TOTAL_W = 16;
    localparam int DELTA_W = 8;
    localparam int STEP_W  = 2;
    localparam int RES_W   = POS_W + 2 * TOTAL_W + DELTA_W + STEP_W;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [2:0] edges_per_detent;
        logic       reverse_direction;
    } qdd_cfg_t;

    typedef struct packed {
        logic [1:0]              prev_ab;
        logic signed [3:0]       edge_sum;
        logic signed [7:0]       pending_delta;
        logic [COUNT_WIDTH-1:0]  position;
        logic [COUNT_WIDTH-1:0]  step_counter;
        logic [COUNT_WIDTH-1:0]  invalid_counter;
    } qdd_state_t;

    typedef struct packed {
        logic signed [STEP_W-1:0]  step_now;
        logic signed [DELTA_W-1:0] delta_taken;
        logic [TOTAL_W-1:0]        invalid_total;
        logic [TOTAL_W-1:0]        step_total;
        logic signed [POS_W-1:0]   position;
    } qdd_result_t;

    // Edge direction for a move from the previous pair (high bits) to the new pair
    function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
        logic signed [1:0] dir;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: dir = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: dir = 2'sd1;
            default:                  dir = 2'sd0;
        endcase
        return dir;
    endfunction

endpackage

`default_nettype wire

FILE: src/qdd_step.sv
// Next-state and result logic for one decoder item.
`default_nettype none

module qdd_step (
    input  qdd_pkg::qdd_cfg_t    cfg,
    input  qdd_pkg::qdd_state_t  state,
    input  logic [1:0]           op,
    input  logic                 pins_flagged,
    input  logic [1:0]           ab_pins,
    output qdd_pkg::qdd_state_t  state_next,
    output qdd_pkg::qdd_result_t result
);
    import qdd_pkg::*;

    logic signed [3:0] lim;
    logic signed [1:0] edge_dir;
    logic signed [3:0] sum;
    logic signed [1:0] made;
    logic signed [1:0] dir;
    logic signed [8:0] pend_sum;
    logic signed [7:0] pend_sat;
    logic signed [7:0] taken;

    // Clamp the detent threshold into 1..4
    always_comb begin
        case (cfg.edges_per_detent)
            3'd0:                   lim = 4'sd1;
            3'd1, 3'd2, 3'd3, 3'd4: lim = 4'(signed'({1'b0, cfg.edges_per_detent}));
            default:                lim = 4'sd4;
        endcase
    end

    // Look up the transition and run the edge accumulator
    assign edge_dir = gray_step({state.prev_ab, ab_pins});
    assign sum      = state.edge_sum + 4'(edge_dir);

    always_comb begin
        if (sum >= lim) begin
            made = 2'sd1;
        end else if (sum <= -lim) begin
            made = -2'sd1;
        end else begin
            made = 2'sd0;
        end
    end

    // Apply the direction setting
    assign dir = cfg.reverse_direction ? -made : made;

    // Saturate the pending delta to eight bits
    assign pend_sum = 9'(state.pending_delta) + 9'(dir);
    always_comb begin
        if (pend_sum > 9'sd127) begin
            pend_sat = 8'sd127;
        end else if (pend_sum < -9'sd128) begin
            pend_sat = -8'sd128;
        end else begin
            pend_sat = pend_sum[7:0];
        end
    end

    // Select the state update for the item kind
    always_comb begin
        state_next = state;
        taken      = 8'sd0;
        case (op)
            OP_SAMPLE: begin
                if (pins_flagged) begin
                    state_next.prev_ab = ab_pins;
                    if (edge_dir == 2'sd0) begin
                        if (ab_pins != state.prev_ab) begin
                            state_next.invalid_counter = state.invalid_counter + 1'b1;
                        end
                    end else begin
                        state_next.edge_sum = (made != 2'sd0) ? 4'sd0 : sum;
                        if (made != 2'sd0) begin
                            state_next.pending_delta = pend_sat;
                            state_next.step_counter  = state.step_counter + 1'b1;
                            state_next.position      = (dir > 2'sd0) ?
                                                       state.position + 1'b1 :
                                                       state.position - 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                taken                    = state.pending_delta;
                state_next.pending_delta = 8'sd0;
            end
            OP_RESYNC: begin
                state_next.prev_ab         = ab_pins;
                state_next.edge_sum        = 4'sd0;
                state_next.pending_delta   = 8'sd0;
                state_next.position        = '0;
                state_next.step_counter    = '0;
                state_next.invalid_counter = '0;
            end
            default: begin
                state_next = state;
            end
        endcase
    end

    // Report the values after the item
    always_comb begin
        result.position      = POS_W'(signed'(state_next.position));
        result.step_total    = TOTAL_W'(state_next.step_counter);
        result.invalid_total = TOTAL_W'(state_next.invalid_counter);
        result.delta_taken   = taken;
        result.step_now      = ((op == OP_SAMPLE) && pins_flagged && (edge_dir != 2'sd0)) ?
                               dir : 2'sd0;
    end

endmodule

`default_nettype wire

FILE: src/quadrature_detent_decoder.sv
// Top level of the quadrature detent decoder: input stage, state, result register.
`default_nettype none

// The decoder takes one item per clock unless the result channel stalls, and
// returns one result per item. An item is held in an input register, passes
// through the transition and accumulator logic, and lands in the result
// register, which presents it until it transfers out; the sustained rate is
// one item per cycle while m_tready stays high, and the single update of the
// decoder state per cycle sets that figure. A stalled result register holds
// its result while the input register still takes one more item. Configuration
// writes take effect at once and are meant for times when no item is in flight.
module quadrature_detent_decoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [2:0]                 cfg_wr_data,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [1:0] ab_pins
    input  logic [2:0]                 s_tuser,   // [1:0] op, [2] pins_flagged
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [qdd_pkg::TDATA_W-1:0] m_tdata   // [15:0] position, [31:16] step_total,
                                                  // [47:32] invalid_total, [55:48] delta_taken,
                                                  // [57:56] step_now
);
    import qdd_pkg::*;

    qdd_cfg_t    cfg_reg;
    qdd_state_t  state_reg;
    qdd_state_t  state_next;
    qdd_result_t result_next;
    qdd_result_t out_res_reg;

    logic       in_vld_reg;
    logic [1:0] in_op_reg;
    logic       in_flag_reg;
    logic [1:0] in_ab_reg;
    logic       out_vld_reg;
    logic       advance;

    // Move the held item on when the result register is free or drains
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edges_per_detent  <= EDGES_RESET;
            cfg_reg.reverse_direction <= REVERSE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EDGES:   cfg_reg.edges_per_detent  <= cfg_wr_data;
                REG_REVERSE: cfg_reg.reverse_direction <= cfg_wr_data[0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Capture an input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser[1:0];
            in_flag_reg <= s_tuser[2];
            in_ab_reg   <= s_tdata[1:0];
        end
    end

    qdd_step u_step (
        .cfg          (cfg_reg),
        .state        (state_reg),
        .op           (in_op_reg),
        .pins_flagged (in_flag_reg),
        .ab_pins      (in_ab_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    // Advance the decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the downstream transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = TDATA_W'(out_res_reg);

    // A step never encodes the unused two-bit code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[57:56] != 2'b10))
        else $error("step_now holds an illegal code");

    // The edge accumulator stays strictly inside the largest threshold
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.edge_sum >= -4'sd3) && (state_reg.edge_sum <= 4'sd3))
        else $error("edge accumulator out of range");

    // A reported step advances the step counter by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (result_next.step_now != 2'sd0)) |=>
        (state_reg.step_counter == $past(state_reg.step_counter) + 1'b1))
        else $error("step made without counter advance");

endmodule

`default_nettype wire
